// ----- src/esud_pkg.sv -----
package esud_pkg;

  // input word width and the resulting day quotient width
  localparam int unsigned SecondsW = 32;
  localparam int unsigned TodW = 17;
  localparam int unsigned DayQuotW = SecondsW - 16;
  localparam int unsigned DayCntW = 2;
  localparam int unsigned TodCntW = 3;

  localparam logic [TodW-1:0] SecsPerDay = TodW'(86400);
  localparam logic [TodW-1:0] SecsPerHour = TodW'(3600);
  localparam logic [TodW-1:0] SecsPerMin = TodW'(60);

  // day count by reciprocal multiply: 86400 = 675 << 7, so the low 7 bits drop out
  localparam int unsigned DayDivInW = SecondsW - 7;
  localparam int unsigned DayRecipW = DayDivInW + 1;
  localparam int unsigned DayRecipSh = DayDivInW + 10;
  localparam int unsigned DayProdW = DayDivInW + DayRecipW;
  localparam logic [DayRecipW-1:0] DayRecip =
    DayRecipW'(((64'd1 << DayRecipSh) + 64'd674) / 64'd675);

  // days / 7 by reciprocal multiply, for the weekday
  localparam int unsigned WkRecipW = DayQuotW + 1;
  localparam int unsigned WkRecipSh = DayQuotW + 3;
  localparam int unsigned WkProdW = DayQuotW + WkRecipW;
  localparam logic [WkRecipW-1:0] WkRecip =
    WkRecipW'(((64'd1 << WkRecipSh) + 64'd6) / 64'd7);

  // hour: 3600 = 225 << 4, minute: 60 = 15 << 2
  localparam int unsigned HourProdW = 27;
  localparam int unsigned HourRecipSh = 21;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam int unsigned MinProdW = 21;
  localparam int unsigned MinRecipSh = 14;
  localparam logic [10:0] MinRecip = 11'd1093;

  // steps of the day split
  localparam logic [DayCntW-1:0] DayQuot = 2'd0;
  localparam logic [DayCntW-1:0] DayRem = 2'd1;
  localparam logic [DayCntW-1:0] DayWeek = 2'd2;

  // steps of the time of day split
  localparam logic [TodCntW-1:0] TodHour = 3'd0;
  localparam logic [TodCntW-1:0] TodHourRem = 3'd1;
  localparam logic [TodCntW-1:0] TodMin = 3'd2;
  localparam logic [TodCntW-1:0] TodMinRem = 3'd3;
  localparam logic [TodCntW-1:0] TodDone = 3'd4;

  // year bookkeeping, starting at 1970
  localparam logic [7:0] StartYear = 8'd70;
  localparam logic [1:0] StartMod4 = 2'd2;
  localparam logic [6:0] StartMod100 = 7'd70;
  localparam logic [8:0] StartMod400 = 9'd370;

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] February = 4'd1;

  typedef struct packed {
    logic load;
    logic day_step;
    logic tod_step;
    logic year_step;
    logic yday_load;
    logic month_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic day_last;
    logic tod_done;
    logic year_done;
    logic month_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } result_t;

  // month lengths of a common year
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1: len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- src/esud_if.sv -----
interface esud_in_if import esud_pkg::*; ();
  logic valid;
  logic ready;
  logic [SecondsW-1:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink (input valid, input seconds_since_epoch, output ready);
endinterface

interface esud_out_if import esud_pkg::*; ();
  logic valid;
  logic ready;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [4:0] day_of_month;
  logic [3:0] month_index;
  logic [7:0] years_since_1900;
  logic [2:0] weekday;
  logic [8:0] day_of_year;

  modport source (
    output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
    output day_of_month, output month_index, output years_since_1900, output weekday,
    output day_of_year, input ready
  );
  modport sink (
    input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
    input day_of_month, input month_index, input years_since_1900, input weekday,
    input day_of_year, output ready
  );
endinterface

// ----- src/esud_datapath.sv -----
module esud_datapath import esud_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [SecondsW-1:0] seconds_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output result_t             result_o
);

  logic [SecondsW-1:0] t_q, t_d;
  logic [TodW-1:0]     part_q, part_d;
  logic [DayQuotW-1:0] days_q, days_d;
  logic [2:0]          q7_q, q7_d;
  logic [2:0]          wmod_q, wmod_d;
  logic [DayCntW-1:0]  day_cnt_q, day_cnt_d;
  logic [TodCntW-1:0]  tod_cnt_q, tod_cnt_d;
  logic [4:0]          hour_q, hour_d;
  logic [5:0]          min_q, min_d;
  logic [7:0]          year_q, year_d;
  logic [1:0]          mod4_q, mod4_d;
  logic [6:0]          mod100_q, mod100_d;
  logic [8:0]          mod400_q, mod400_d;
  logic [8:0]          yday_q, yday_d;
  logic [3:0]          month_q, month_d;
  result_t             res_q, res_d;
  logic                out_valid_q, out_valid_d;

  logic [DayProdW-1:0]  day_prod;
  logic [WkProdW-1:0]   wk_prod;
  logic [TodW-1:0]      day_secs;
  logic [HourProdW-1:0] hour_prod;
  logic [TodW-1:0]      hour_secs;
  logic [MinProdW-1:0]  min_prod;
  logic [TodW-1:0]      min_secs;
  logic                 leap;
  logic [8:0]           ylen;
  logic [4:0]           mlen;
  logic [3:0]           wsum;
  logic [2:0]           wday;

  // days = seconds / 86400: drop the 7 zero bits of 86400, multiply by 2^k / 675
  assign day_prod = DayProdW'(t_q[SecondsW-1:7]) * DayProdW'(DayRecip);
  // days / 7, only the low quotient bits are needed for days mod 7
  assign wk_prod  = WkProdW'(days_q) * WkProdW'(WkRecip);
  // low bits of days * 86400 are enough, the remainder is below 86400
  assign day_secs = TodW'(days_q) * SecsPerDay;

  // hour from the time of day, then minute from what is left below 3600
  assign hour_prod = HourProdW'(part_q[TodW-1:4]) * HourProdW'(HourRecip);
  assign hour_secs = TodW'(hour_q) * SecsPerHour;
  assign min_prod  = MinProdW'(part_q[11:2]) * MinProdW'(MinRecip);
  assign min_secs  = TodW'(min_q) * SecsPerMin;

  assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = (leap && (month_q == February)) ? 5'd29 : month_len(month_q);

  assign wsum = {1'b0, wmod_q} + 4'd4;
  assign wday = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];

  always_comb begin
    t_d       = t_q;
    part_d    = part_q;
    days_d    = days_q;
    q7_d      = q7_q;
    wmod_d    = wmod_q;
    day_cnt_d = day_cnt_q;
    tod_cnt_d = tod_cnt_q;
    hour_d    = hour_q;
    min_d     = min_q;
    year_d    = year_q;
    mod4_d    = mod4_q;
    mod100_d  = mod100_q;
    mod400_d  = mod400_q;
    yday_d    = yday_q;
    month_d   = month_q;
    res_d     = res_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      t_d       = seconds_i;
      days_d    = '0;
      wmod_d    = '0;
      day_cnt_d = '0;
      tod_cnt_d = '0;
      hour_d    = '0;
      min_d     = '0;
      year_d    = StartYear;
      mod4_d    = StartMod4;
      mod100_d  = StartMod100;
      mod400_d  = StartMod400;
      month_d   = '0;
    end

    if (cmd_i.day_step) begin
      case (day_cnt_q)
        DayQuot: begin
          days_d = day_prod[DayRecipSh +: DayQuotW];
        end
        DayRem: begin
          part_d = t_q[TodW-1:0] - day_secs;
          q7_d   = wk_prod[WkRecipSh +: 3];
        end
        default: begin
          // days - 7q equals days + q modulo 8, and the true value is below 7
          wmod_d = days_q[2:0] + q7_q;
        end
      endcase
      day_cnt_d = day_cnt_q + DayCntW'(1);
    end

    if (cmd_i.tod_step) begin
      case (tod_cnt_q)
        TodHour: begin
          hour_d = hour_prod[HourRecipSh +: 5];
        end
        TodHourRem: begin
          part_d = part_q - hour_secs;
        end
        TodMin: begin
          min_d = min_prod[MinRecipSh +: 6];
        end
        default: begin
          part_d = part_q - min_secs;
        end
      endcase
      tod_cnt_d = tod_cnt_q + TodCntW'(1);
    end

    if (cmd_i.year_step) begin
      days_d   = days_q - DayQuotW'(ylen);
      year_d   = year_q + 8'd1;
      mod4_d   = mod4_q + 2'd1;
      mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end

    if (cmd_i.yday_load) begin
      yday_d = days_q[8:0];
    end

    if (cmd_i.month_step) begin
      days_d  = days_q - DayQuotW'(mlen);
      month_d = month_q + 4'd1;
    end

    if (cmd_i.out_load) begin
      res_d.second_of_minute = part_q[5:0];
      res_d.minute_of_hour   = min_q;
      res_d.hour_of_day      = hour_q;
      res_d.day_of_month     = days_q[4:0] + 5'd1;
      res_d.month_index      = month_q;
      res_d.years_since_1900 = year_q;
      res_d.weekday          = wday;
      res_d.day_of_year      = yday_q;
      out_valid_d            = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    part_q    <= part_d;
    days_q    <= days_d;
    q7_q      <= q7_d;
    wmod_q    <= wmod_d;
    day_cnt_q <= day_cnt_d;
    tod_cnt_q <= tod_cnt_d;
    hour_q    <= hour_d;
    min_q     <= min_d;
    year_q    <= year_d;
    mod4_q    <= mod4_d;
    mod100_q  <= mod100_d;
    mod400_q  <= mod400_d;
    yday_q    <= yday_d;
    month_q   <= month_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.day_last   = day_cnt_q == DayWeek;
  assign status_o.tod_done   = tod_cnt_q == TodDone;
  assign status_o.year_done  = days_q < DayQuotW'(ylen);
  assign status_o.month_done = (month_q == LastMonth) || (days_q < DayQuotW'(mlen));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ----- src/esud_ctrl.sv -----
module esud_ctrl import esud_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StDay     = 5'b00010,
    StTodYear = 5'b00100,
    StMonth   = 5'b01000,
    StDone    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDay;
        end
      end
      StDay: begin
        cmd_o.day_step = 1'b1;
        if (status_i.day_last) begin
          state_d = StTodYear;
        end
      end
      StTodYear: begin
        // time of day and year search run side by side
        cmd_o.tod_step  = !status_i.tod_done;
        cmd_o.year_step = !status_i.year_done;
        if (status_i.tod_done && status_i.year_done) begin
          cmd_o.yday_load = 1'b1;
          state_d         = StMonth;
        end
      end
      StMonth: begin
        if (status_i.month_done) begin
          state_d = StDone;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == StIdle;

endmodule

// ----- src/epoch_seconds_to_utc_date.sv -----
// epoch seconds to utc calendar date
//
// in_i carries one word: an unsigned count of seconds since 1970-01-01 utc.
// out_o gives one word per input: second, minute, hour, day of month, month,
// years since 1900, weekday (0 sunday) and day of year.
// both channels use valid/ready; a word moves when both are high.
//
// one word at a time: after acceptance the controller runs these steps in order:
//   StDay: splitting days from the time of day and finding the weekday
//   StTodYear: hour/minute split next to the year search
//   StMonth: month search; StDone: load the result register
// the result shows once it is in the output register, and the next word can be
// taken in that same cycle. the year search loop is the longest step, and a word
// takes longest for a date in december 2105.
// in_ready is high only while the controller is idle.
// the result sits in an output register, so a new word is taken while the last
// result waits; a stalled receiver holds the next result in the datapath.
// reset clears the controller and the output valid; a word in flight is lost, none made up.
module epoch_seconds_to_utc_date import esud_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  esud_in_if.sink     in_i,
  esud_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;
  result_t result;

  esud_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  esud_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .seconds_i   (in_i.seconds_since_epoch),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .result_o    (result)
  );

  assign out_o.second_of_minute = result.second_of_minute;
  assign out_o.minute_of_hour   = result.minute_of_hour;
  assign out_o.hour_of_day      = result.hour_of_day;
  assign out_o.day_of_month     = result.day_of_month;
  assign out_o.month_index      = result.month_index;
  assign out_o.years_since_1900 = result.years_since_1900;
  assign out_o.weekday          = result.weekday;
  assign out_o.day_of_year      = result.day_of_year;

endmodule
